// ===== rtl/sha256_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and round functions of the SHA-256 hash engine.
package sha256_pkg;

    typedef logic [7:0][31:0]  word8_t;
    typedef logic [15:0][31:0] window_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } state_t;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;

    // Index 0 holds H0.
    localparam word8_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

// ===== rtl/sha256_round.sv =====
`timescale 1ns / 1ps
// One SHA-256 compression round and one message schedule step.
module sha256_round
(
    input  sha256_pkg::word8_t  work_in,
    input  sha256_pkg::window_t window_in,
    input  logic [31:0]         k_in,
    output sha256_pkg::word8_t  work_out,
    output logic [31:0]         w_new
);

    logic [31:0] w_cur;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;

    // The window holds W[t] in its top word and W[t+15] in its bottom word.
    assign w_cur = window_in[15];
    assign w_new = sha256_pkg::small_sigma1(window_in[1]) + window_in[6]
                 + sha256_pkg::small_sigma0(window_in[14]) + window_in[15];

    assign ch  = (work_in[4] & work_in[5]) ^ (~work_in[4] & work_in[6]);
    assign maj = (work_in[0] & work_in[1]) ^ (work_in[0] & work_in[2])
               ^ (work_in[1] & work_in[2]);
    assign t1  = work_in[7] + sha256_pkg::big_sigma1(work_in[4]) + ch + k_in + w_cur;
    assign t2  = sha256_pkg::big_sigma0(work_in[0]) + maj;

    always_comb
    begin
        work_out[0] = t1 + t2;
        work_out[1] = work_in[0];
        work_out[2] = work_in[1];
        work_out[3] = work_in[2];
        work_out[4] = work_in[3] + t1;
        work_out[5] = work_in[4];
        work_out[6] = work_in[5];
        work_out[7] = work_in[6];
    end

endmodule

// ===== rtl/sha256_hash_engine.sv =====
`timescale 1ns / 1ps
// Top level of the SHA-256 hash engine: byte packing, padding, sequencing, digest output.
//
// The engine hashes a byte stream with SHA-256. Each input word carries at most one
// message byte and may close the message. Message bytes are taken one per cycle while
// the 64-byte block is filling; the 64th byte starts the rounds and a final step that
// folds the result into the chaining value, during which the input is stalled. All
// rounds go through a single round unit, and the 512-bit block register doubles as
// the message schedule window. When a word with end_of_message is taken, the engine
// appends the 0x80 marker, zero fill and the 64-bit bit length one byte per cycle,
// and each padded block is followed by a compression. When the length does not fit
// in the current block, a second padding block and another compression follow. The
// engine then offers the eight digest words, word 0 first, with last_word on word 7.
// The output holds each word until it is taken; after word 7 the engine returns to
// the initial hash values and accepts the next message. A word without a byte and
// without the end mark is accepted and does nothing. The byte count wraps at 2^61.
module sha256_hash_engine
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha256_pkg::state_t  state_reg, state_next;
    sha256_pkg::word8_t  chain_reg, chain_next;
    sha256_pkg::word8_t  work_reg, work_next;
    sha256_pkg::window_t block_reg, block_next;
    logic [5:0]          fill_reg, fill_next;
    logic [60:0]         count_reg, count_next;
    logic [5:0]          round_reg, round_next;
    logic [2:0]          idx_reg, idx_next;
    logic                pad_active_reg, pad_active_next;
    logic                pad_first_reg, pad_first_next;
    logic                len_phase_reg, len_phase_next;
    logic                len_done_reg, len_done_next;

    logic                in_acc;
    logic                out_acc;
    logic                out_done;
    logic                push_en;
    logic [7:0]          push_byte;
    logic                len_byte_sel;
    logic [63:0]         len_bits;
    logic [5:0]          len_shift;
    logic [511:0]        block_flat;
    sha256_pkg::word8_t  work_round;
    logic [31:0]         w_new;

    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid && !out_stall;
    assign out_done = out_acc && (idx_reg == sha256_pkg::WORD_LAST);

    assign len_bits   = {count_reg, 3'b000};
    assign len_shift  = {3'd7 - fill_reg[2:0], 3'b000};
    assign block_flat = block_reg;

    // Shared round unit; it works on the block register as the schedule window.
    sha256_round u_round
    (
        .work_in   (work_reg),
        .window_in (block_reg),
        .k_in      (sha256_pkg::ROUND_K[round_reg]),
        .work_out  (work_round),
        .w_new     (w_new)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (has_byte && (fill_reg == sha256_pkg::FILL_LAST))
                    begin
                        state_next = sha256_pkg::ST_ROUND;
                    end
                    else if (end_of_message)
                    begin
                        state_next = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_PAD:
            begin
                if (fill_reg == sha256_pkg::FILL_LAST)
                begin
                    state_next = sha256_pkg::ST_ROUND;
                end
            end
            sha256_pkg::ST_ROUND:
            begin
                if (round_reg == sha256_pkg::ROUND_LAST)
                begin
                    state_next = sha256_pkg::ST_FINAL;
                end
            end
            sha256_pkg::ST_FINAL:
            begin
                if (len_done_reg)
                begin
                    state_next = sha256_pkg::ST_OUT;
                end
                else if (pad_active_reg)
                begin
                    state_next = sha256_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha256_pkg::ST_IDLE;
                end
            end
            sha256_pkg::ST_OUT:
            begin
                if (out_done)
                begin
                    state_next = sha256_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sha256_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake and byte push controls.
    always_comb
    begin
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        push_en      = 1'b0;
        push_byte    = data_byte;
        len_byte_sel = 1'b0;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                push_en  = in_valid && has_byte;
            end
            sha256_pkg::ST_PAD:
            begin
                push_en = 1'b1;
                if (pad_first_reg)
                begin
                    push_byte = sha256_pkg::PAD_MARK;
                end
                else if (len_phase_reg || (fill_reg == sha256_pkg::LEN_START))
                begin
                    len_byte_sel = 1'b1;
                    push_byte    = len_bits[len_shift +: 8];
                end
                else
                begin
                    push_byte = 8'h00;
                end
            end
            sha256_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        block_next      = block_reg;
        fill_next       = fill_reg;
        count_next      = count_reg;
        round_next      = round_reg;
        idx_next        = idx_reg;
        work_next       = work_reg;
        chain_next      = chain_reg;
        pad_active_next = pad_active_reg;
        pad_first_next  = pad_first_reg;
        len_phase_next  = len_phase_reg;
        len_done_next   = len_done_reg;

        if (push_en)
        begin
            block_next = sha256_pkg::window_t'({block_flat[503:0], push_byte});
            fill_next  = fill_reg + 6'd1;
        end
        else if (state_reg == sha256_pkg::ST_ROUND)
        begin
            block_next = sha256_pkg::window_t'({block_reg[14:0], w_new});
        end

        if (in_acc && has_byte)
        begin
            count_next = count_reg + 61'd1;
        end
        if (in_acc && end_of_message)
        begin
            pad_active_next = 1'b1;
            pad_first_next  = 1'b1;
        end

        if (state_reg == sha256_pkg::ST_PAD)
        begin
            pad_first_next = 1'b0;
            if (len_byte_sel)
            begin
                len_phase_next = 1'b1;
                if (fill_reg == sha256_pkg::FILL_LAST)
                begin
                    len_done_next = 1'b1;
                end
            end
        end

        // Working variables start from the chaining value for every block.
        if ((state_next == sha256_pkg::ST_ROUND) && (state_reg != sha256_pkg::ST_ROUND))
        begin
            work_next  = chain_reg;
            round_next = 6'd0;
        end
        else if (state_reg == sha256_pkg::ST_ROUND)
        begin
            work_next  = work_round;
            round_next = round_reg + 6'd1;
        end

        if (state_reg == sha256_pkg::ST_FINAL)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = chain_reg[i] + work_reg[i];
            end
        end

        if (out_acc)
        begin
            idx_next = idx_reg + 3'd1;
        end
        if (out_done)
        begin
            chain_next      = sha256_pkg::INIT_HASH;
            count_next      = 61'd0;
            pad_active_next = 1'b0;
            pad_first_next  = 1'b0;
            len_phase_next  = 1'b0;
            len_done_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sha256_pkg::ST_IDLE;
            chain_reg      <= sha256_pkg::INIT_HASH;
            work_reg       <= '0;
            fill_reg       <= '0;
            count_reg      <= '0;
            round_reg      <= '0;
            idx_reg        <= '0;
            pad_active_reg <= 1'b0;
            pad_first_reg  <= 1'b0;
            len_phase_reg  <= 1'b0;
            len_done_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            chain_reg      <= chain_next;
            work_reg       <= work_next;
            fill_reg       <= fill_next;
            count_reg      <= count_next;
            round_reg      <= round_next;
            idx_reg        <= idx_next;
            pad_active_reg <= pad_active_next;
            pad_first_reg  <= pad_first_next;
            len_phase_reg  <= len_phase_next;
            len_done_reg   <= len_done_next;
        end
    end

    // The block register holds only message, padding and schedule words and needs no reset.
    always_ff @(posedge clk)
    begin
        block_reg <= block_next;
    end

    assign digest_word = chain_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == sha256_pkg::WORD_LAST);

    // A digest always starts at word 0.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (word_index == 3'd0))
    else $error("digest did not start at word 0");

    // Taking the last word ends the digest.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_word) |=> !out_valid)
    else $error("output still valid after the last digest word");

    // An end mark starts padding or, on the 64th byte, the rounds, so the input must stall next.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && end_of_message) |=> in_stall)
    else $error("input not stalled after end of message");

    // The final round is always followed by the chaining update.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == sha256_pkg::ST_ROUND) && (round_reg == sha256_pkg::ROUND_LAST))
        |=> (state_reg == sha256_pkg::ST_FINAL))
    else $error("missing chaining update after round 63");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the SHA-256 hash engine with its own digest predictor.
module tb_top;

    // Round constants and initial hash words of FIPS 180-4. The testbench keeps
    // its own copies, so a wrong constant in the design cannot go unnoticed.
    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] HASH_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // The padding marker that follows the last message byte, and the block
    // offset at which the 64-bit length field begins.
    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam int         LENGTH_SLOT  = 56;
    localparam int         BLOCK_BYTES  = 64;

    // Message lengths that sit right at the padding boundaries: 55 bytes still
    // leave room for the marker and the length, 56 and 63 push the length into
    // a second block, and 64 fills a block exactly. Each phase opens with one.
    localparam int EDGE_LENGTHS [4] = '{55, 56, 63, 64};

    // Cycles to keep watching the output once nothing is expected any more.
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [31:0] value;
        logic [2:0]  index;
        logic        last;
    } digest_entry_t;

    // Tracks the hash state of the message in flight and holds the digest
    // words that the engine still owes, oldest first.
    class digest_tracker;

        logic [31:0]   chain [8];
        logic [7:0]    block [64];
        int            fill;
        logic [60:0]   byte_count;
        digest_entry_t words_due [$];
        int            errors;

        function new();
            restart();
            errors = 0;
        endfunction

        function void restart();
            foreach (chain[i]) chain[i] = HASH_START[i];
            fill       = 0;
            byte_count = '0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // One full 64-round compression of the current block into the chain.
        function void compress();
            logic [31:0] sched [64];
            logic [31:0] v [8];
            logic [31:0] t1;
            logic [31:0] t2;
            for (int i = 0; i < 16; i++)
                sched[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
            for (int i = 16; i < 64; i++)
                sched[i] = (ror(sched[i-2], 17) ^ ror(sched[i-2], 19) ^ (sched[i-2] >> 10))
                         + sched[i-7]
                         + (ror(sched[i-15], 7) ^ ror(sched[i-15], 18) ^ (sched[i-15] >> 3))
                         + sched[i-16];
            foreach (v[i]) v[i] = chain[i];
            for (int r = 0; r < 64; r++)
            begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + sched[r];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            foreach (chain[i]) chain[i] = chain[i] + v[i];
        endfunction

        function void append_byte(logic [7:0] b);
            block[fill] = b;
            fill++;
            if (fill == BLOCK_BYTES)
            begin
                compress();
                fill = 0;
            end
        endfunction

        // Called for every input word the engine accepts.
        function void note_word(logic [7:0] data, logic has, logic eom);
            logic [63:0]   bit_len;
            digest_entry_t entry;
            if (has)
            begin
                byte_count = byte_count + 1'b1;
                append_byte(data);
            end
            if (eom)
            begin
                bit_len = {byte_count, 3'b000};
                append_byte(PAD_BYTE);
                while (fill != LENGTH_SLOT) append_byte(8'h00);
                for (int i = 0; i < 8; i++) append_byte(bit_len[63 - 8*i -: 8]);
                for (int i = 0; i < 8; i++)
                begin
                    entry.value = chain[i];
                    entry.index = 3'(i);
                    entry.last  = (3'(i) == sha256_pkg::WORD_LAST);
                    words_due.push_back(entry);
                end
                restart();
            end
        endfunction

        // Called for every digest word the testbench takes from the engine.
        function void check_word(logic [31:0] value, logic [2:0] index, logic last);
            digest_entry_t want;
            if (words_due.size() == 0)
            begin
                $display("%0t: unexpected digest word %h index %0d last %0b",
                         $time, value, index, last);
                errors++;
                return;
            end
            want = words_due.pop_front();
            if (value !== want.value)
            begin
                $display("%0t: digest_word expected %h actual %h", $time, want.value, value);
                errors++;
            end
            if (index !== want.index)
            begin
                $display("%0t: word_index expected %0d actual %0d", $time, want.index, index);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_word expected %0b actual %0b", $time, want.last, last);
                errors++;
            end
        endfunction

    endclass

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte      = 8'h00;
    logic        has_byte       = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    // Idle and stall rates in percent, changed from phase to phase.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          words_sent     = 0;

    digest_tracker tracker;

    sha256_hash_engine dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    always #6 clk = ~clk;

    // Offers one input word and returns at the rising edge that accepts it.
    // Stall is sampled at the falling edge, where everything driven at the
    // last rising edge has settled and nothing changes until the next one, so
    // the accept decision never races with the design's own updates.
    task automatic send_word(logic [7:0] data, logic has, logic eom);
        logic stalled;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= data;
        has_byte       <= has;
        end_of_message <= eom;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        tracker.note_word(data, has, eom);
        words_sent++;
    endtask

    // Sends a message of random bytes. The end mark either rides on the last
    // byte or comes as a word of its own without a byte; an empty message
    // always takes the latter form. Words carrying neither a byte nor the end
    // mark are sprinkled in, with random data that the engine must ignore.
    task automatic send_message(int length, bit mark_on_byte);
        for (int i = 0; i < length; i++)
        begin
            if ($urandom_range(9) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1, mark_on_byte && (i == length - 1));
        end
        if (!mark_on_byte || length == 0)
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // Result side: decide at the falling edge whether the coming rising edge
    // takes a digest word, check it at that edge, then pick the next stall.
    always
    begin : digest_sink
        logic        take;
        logic [31:0] value;
        logic [2:0]  index;
        logic        last;
        @(negedge clk);
        take  = rst_n && out_valid && !out_stall;
        value = digest_word;
        index = word_index;
        last  = last_word;
        @(posedge clk);
        if (take)
            tracker.check_word(value, index, last);
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin : stimulus
        int phase_start;
        int length;
        tracker = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A word with neither byte nor end mark must do nothing,
        // even with all data bits set.
        send_word(8'hff, 1'b0, 1'b0);
        // End mark as the very first word: digest of the empty message.
        send_word(8'h00, 1'b0, 1'b1);
        // The classic three-byte message, end mark on the last byte.
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        // Single zero byte carrying the end mark.
        send_word(8'h00, 1'b1, 1'b1);
        // All-ones byte, an ignored word in the middle, then an end mark
        // without a byte, so the digest covers only the one byte.
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h5a, 1'b0, 1'b0);
        send_word(8'ha5, 1'b0, 1'b1);
        // Bytes that look like padding and its complement.
        send_word(PAD_BYTE, 1'b1, 1'b0);
        send_word(8'h7f, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        // Two empty messages back to back.
        send_word(8'hff, 1'b0, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);

        // Random part in four phases of idling and stalling. Each phase opens with a
        // message whose length sits on a padding boundary, then runs random
        // messages, mostly short, some long enough to take two blocks.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 65;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 65;
                end
                default:
                begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 12;
                end
            endcase
            phase_start = words_sent;
            send_message(EDGE_LENGTHS[ph], 1'($urandom_range(1)));
            while (words_sent - phase_start < 62)
            begin
                if ($urandom_range(99) < 60)
                    length = $urandom_range(12);
                else
                    length = $urandom_range(72, 50);
                send_message(length, 1'($urandom_range(1)));
            end
        end
        in_valid <= 1'b0;

        // Wait for every digest word, then keep watching for stray output.
        while (tracker.words_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0 && tracker.words_due.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Safety net against a hung handshake: a correct run ends far earlier.
    initial
    begin : watchdog
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
